[sv/sst_pkg.sv]
`default_nettype none

package sst_pkg;

  parameter int unsigned EntitySlotsDefault    = 4096;
  parameter int unsigned DenseCapacityDefault  = 1024;
  parameter int unsigned PayloadBitsDefault    = 64;
  parameter int unsigned GenerationBitsDefault = 16;

  localparam int unsigned OpcodeW   = 2;
  localparam int unsigned SlotW     = 12;
  localparam int unsigned GenPortW  = 16;
  localparam int unsigned DataW     = 64;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned PosOutW   = 10;
  localparam int unsigned CountOutW = 11;

  typedef enum logic [OpcodeW-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2,
    OP_WRITE  = 2'd3
  } opcode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_PRESENT   = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_LOOK  = 5'b00100,
    S_CHECK = 5'b01000,
    S_FIX   = 5'b10000
  } state_e;

endpackage

`default_nettype wire

[sv/sst_ram.sv]
`default_nettype none

module sst_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[sv/sparse_set_table.sv]
// Sparse-set table: maps entity handles (slot plus generation) to a packed
// dense array of payload words.
// Input channel: in_valid_i/in_ready_o with opcode_i, handle_set_i,
// entity_slot_i, entity_generation_i and fragment_data_i. Each transaction
// produces exactly one result transaction on out_valid_o/out_ready_i with
// status_o, dense_position_o, found_data_o and entry_count_o.
// One operation is in flight at a time. The result is registered in S_LOOK
// for add and for an unset or out-of-range handle, in S_CHECK for find,
// overwrite and a failed remove, and in S_FIX for a successful remove. The
// next transaction can be accepted in the cycle after the result is
// registered. These steps follow from the chain of dependent reads on the
// synchronous memories: sparse map, then dense entry, then the second sparse
// map write that a remove needs.
// After reset the block sweeps the sparse map to empty, one entry per cycle;
// in_ready_o stays low during the sweep.
// A result waits in the output register while the receiver stalls; the next
// transaction is still accepted, and the block then holds that transaction in
// its final step, with in_ready_o low, until the register drains.
`default_nettype none

module sparse_set_table #(
  parameter int unsigned ENTITY_SLOTS    = sst_pkg::EntitySlotsDefault,
  parameter int unsigned DENSE_CAPACITY  = sst_pkg::DenseCapacityDefault,
  parameter int unsigned PAYLOAD_BITS    = sst_pkg::PayloadBitsDefault,
  parameter int unsigned GENERATION_BITS = sst_pkg::GenerationBitsDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [sst_pkg::OpcodeW-1:0]    opcode_i,
  input  wire logic                           handle_set_i,
  input  wire logic [sst_pkg::SlotW-1:0]      entity_slot_i,
  input  wire logic [sst_pkg::GenPortW-1:0]   entity_generation_i,
  input  wire logic [sst_pkg::DataW-1:0]      fragment_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic      [sst_pkg::StatusW-1:0]    status_o,
  output logic      [sst_pkg::PosOutW-1:0]    dense_position_o,
  output logic      [sst_pkg::DataW-1:0]      found_data_o,
  output logic      [sst_pkg::CountOutW-1:0]  entry_count_o
);

  localparam int unsigned SlotAw = $clog2(ENTITY_SLOTS);
  localparam int unsigned PosW   = $clog2(DENSE_CAPACITY);
  localparam int unsigned CntW   = $clog2(DENSE_CAPACITY + 1);
  localparam int unsigned GenW   = (GENERATION_BITS < sst_pkg::GenPortW) ?
                                   GENERATION_BITS : sst_pkg::GenPortW;
  localparam int unsigned PayW   = (PAYLOAD_BITS < sst_pkg::DataW) ?
                                   PAYLOAD_BITS : sst_pkg::DataW;
  localparam int unsigned MapW   = PosW + 1;
  localparam int unsigned DenseW = SlotAw + GenW + PayW;

  typedef struct packed {
    logic            valid;
    logic [PosW-1:0] pos;
  } map_t;

  typedef struct packed {
    logic [SlotAw-1:0] slot;
    logic [GenW-1:0]   gen;
    logic [PayW-1:0]   pay;
  } dense_t;

  sst_pkg::state_e  state_q, state_d;
  logic [SlotAw-1:0] clr_q, clr_d;
  logic [CntW-1:0]   count_q, count_d;

  sst_pkg::opcode_e  op_q;
  logic              inok_q;
  logic [SlotAw-1:0] slot_q;
  logic [GenW-1:0]   gen_q;
  logic [PayW-1:0]   pay_q;
  dense_t            moved_q;

  logic              out_valid_q;
  sst_pkg::status_e  status_q;
  logic [PosW-1:0]   pos_q;
  logic [PayW-1:0]   found_q;
  logic [CntW-1:0]   cnt_q;

  logic              map_we, map_re;
  logic [SlotAw-1:0] map_waddr, map_raddr;
  map_t              map_wdata, map_rd;
  logic [MapW-1:0]   map_rdata;

  logic              dense_we, dense_re;
  logic [PosW-1:0]   dense_waddr, dense_raddr;
  dense_t            dense_wdata, dense_rd;
  logic [DenseW-1:0] dense_rdata;

  logic              accept, out_free, hit, full;
  logic [PosW-1:0]   last_pos;
  logic              load;
  sst_pkg::status_e  res_status;
  logic [PosW-1:0]   res_pos;
  logic [PayW-1:0]   res_data;

  sst_ram #(
    .Width(MapW),
    .Depth(ENTITY_SLOTS)
  ) u_map_ram (
    .clk_i  (clk_i),
    .we_i   (map_we),
    .waddr_i(map_waddr),
    .wdata_i(map_wdata),
    .re_i   (map_re),
    .raddr_i(map_raddr),
    .rdata_o(map_rdata)
  );

  sst_ram #(
    .Width(DenseW),
    .Depth(DENSE_CAPACITY)
  ) u_dense_ram (
    .clk_i  (clk_i),
    .we_i   (dense_we),
    .waddr_i(dense_waddr),
    .wdata_i(dense_wdata),
    .re_i   (dense_re),
    .raddr_i(dense_raddr),
    .rdata_o(dense_rdata)
  );

  assign map_rd   = map_t'(map_rdata);
  assign dense_rd = dense_t'(dense_rdata);

  assign in_ready_o = (state_q == sst_pkg::S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign full       = count_q >= CntW'(DENSE_CAPACITY);
  assign last_pos   = PosW'(count_q - CntW'(1));
  assign hit        = map_rd.valid && (CntW'(map_rd.pos) < count_q) &&
                      (dense_rd.slot == slot_q) && (dense_rd.gen == gen_q);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    count_d     = count_q;
    map_we      = 1'b0;
    map_waddr   = slot_q;
    map_wdata   = '0;
    map_re      = 1'b0;
    map_raddr   = SlotAw'(entity_slot_i);
    dense_we    = 1'b0;
    dense_waddr = map_rd.pos;
    dense_wdata = '{slot: slot_q, gen: gen_q, pay: pay_q};
    dense_re    = 1'b0;
    dense_raddr = last_pos;
    load        = 1'b0;
    res_status  = sst_pkg::ST_NOT_FOUND;
    res_pos     = '0;
    res_data    = '0;

    unique case (state_q)
      sst_pkg::S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_q;
        if (clr_q == SlotAw'(ENTITY_SLOTS - 1)) begin
          state_d = sst_pkg::S_IDLE;
        end else begin
          clr_d = clr_q + SlotAw'(1);
        end
      end
      sst_pkg::S_IDLE: begin
        if (accept) begin
          map_re   = 1'b1;
          dense_re = 1'b1;
          state_d  = sst_pkg::S_LOOK;
        end
      end
      sst_pkg::S_LOOK: begin
        priority if (!inok_q) begin
          if (out_free) begin
            load    = 1'b1;
            state_d = sst_pkg::S_IDLE;
          end
        end else if (op_q == sst_pkg::OP_ADD) begin
          if (out_free) begin
            load    = 1'b1;
            state_d = sst_pkg::S_IDLE;
            priority if (map_rd.valid) begin
              res_status = sst_pkg::ST_PRESENT;
            end else if (full) begin
              res_status = sst_pkg::ST_FULL;
            end else begin
              res_status  = sst_pkg::ST_OK;
              res_pos     = count_q[PosW-1:0];
              dense_we    = 1'b1;
              dense_waddr = count_q[PosW-1:0];
              map_we      = 1'b1;
              map_wdata   = '{valid: 1'b1, pos: count_q[PosW-1:0]};
              count_d     = count_q + CntW'(1);
            end
          end
        end else begin
          dense_re    = 1'b1;
          dense_raddr = map_rd.pos;
          state_d     = sst_pkg::S_CHECK;
        end
      end
      sst_pkg::S_CHECK: begin
        if (!hit) begin
          if (out_free) begin
            load    = 1'b1;
            state_d = sst_pkg::S_IDLE;
          end
        end else begin
          unique case (op_q)
            sst_pkg::OP_REMOVE: begin
              if (map_rd.pos != last_pos) begin
                dense_we    = 1'b1;
                dense_wdata = moved_q;
                map_we      = 1'b1;
                map_waddr   = moved_q.slot;
                map_wdata   = '{valid: 1'b1, pos: map_rd.pos};
              end
              state_d = sst_pkg::S_FIX;
            end
            sst_pkg::OP_WRITE: begin
              if (out_free) begin
                load        = 1'b1;
                res_status  = sst_pkg::ST_OK;
                res_pos     = map_rd.pos;
                dense_we    = 1'b1;
                dense_wdata = '{slot: dense_rd.slot, gen: dense_rd.gen, pay: pay_q};
                state_d     = sst_pkg::S_IDLE;
              end
            end
            default: begin
              if (out_free) begin
                load       = 1'b1;
                res_status = sst_pkg::ST_OK;
                res_pos    = map_rd.pos;
                res_data   = dense_rd.pay;
                state_d    = sst_pkg::S_IDLE;
              end
            end
          endcase
        end
      end
      sst_pkg::S_FIX: begin
        if (out_free) begin
          map_we     = 1'b1;
          count_d    = count_q - CntW'(1);
          load       = 1'b1;
          res_status = sst_pkg::ST_OK;
          res_pos    = map_rd.pos;
          state_d    = sst_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = sst_pkg::S_CLEAR;
        clr_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sst_pkg::S_CLEAR;
      clr_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      count_q <= count_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= sst_pkg::opcode_e'(opcode_i);
      inok_q <= handle_set_i && (32'(entity_slot_i) < 32'(ENTITY_SLOTS));
      slot_q <= SlotAw'(entity_slot_i);
      gen_q  <= entity_generation_i[GenW-1:0];
      pay_q  <= fragment_data_i[PayW-1:0];
    end
    if (state_q == sst_pkg::S_LOOK) begin
      moved_q <= dense_rd;
    end
    if (load) begin
      status_q <= res_status;
      pos_q    <= res_pos;
      found_q  <= res_data;
      cnt_q    <= count_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign dense_position_o = sst_pkg::PosOutW'(pos_q);
  assign found_data_o     = sst_pkg::DataW'(found_q);
  assign entry_count_o    = sst_pkg::CountOutW'(cnt_q);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DENSE_CAPACITY))
    else $error("live count exceeds dense capacity");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == $past(count_q) + CntW'(1) || count_q == $past(count_q) - CntW'(1)))
    else $error("live count moved by more than one");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sst_pkg::S_IDLE) |-> !(map_we || dense_we))
    else $error("memory written while idle");

  a_ok_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && res_status == sst_pkg::ST_OK) |-> (CntW'(res_pos) <= count_d))
    else $error("dense position of a successful transaction out of range");
`endif

endmodule

`default_nettype wire
